[rtl/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the two-stack cpu core step block.
// ----------------------------------------------------------------------------
package scc_pkg;

	localparam int unsigned MemWordsDef     = 4096;
	localparam int unsigned DataDepthDef    = 32;
	localparam int unsigned ReturnDepthDef  = 32;

	typedef enum logic [4:0] {
		OP_FETCH       = 5'd0,
		OP_NOP         = 5'd1,
		OP_JMP         = 5'd2,
		OP_JMPZ        = 5'd3,
		OP_JMPN        = 5'd4,
		OP_CALL        = 5'd5,
		OP_RET         = 5'd6,
		OP_DUP         = 5'd7,
		OP_DROP        = 5'd8,
		OP_OVER        = 5'd9,
		OP_ADD         = 5'd14,
		OP_SUB         = 5'd15,
		OP_MUL         = 5'd16,
		OP_SHR         = 5'd17,
		OP_SHL         = 5'd18,
		OP_NOT         = 5'd19,
		OP_AND         = 5'd20,
		OP_XOR         = 5'd21,
		OP_OR          = 5'd22,
		OP_LIT         = 5'd23,
		OP_LIT_1       = 5'd24,
		OP_LOAD_A      = 5'd25,
		OP_STORE_A     = 5'd26,
		OP_LOAD_A_INC  = 5'd27,
		OP_STORE_A_INC = 5'd28,
		OP_BUILTIN     = 5'd31
	} op_t;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_PUSH  = 2'd1,
		KIND_EXEC  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TRAP     = 2'd1,
		ST_DATA_ERR = 2'd2,
		ST_RET_ERR  = 2'd3
	} status_t;

endpackage

[rtl/stack_cpu_core_step.sv]
// ----------------------------------------------------------------------------
// stack_cpu_core_step
// Two-stack cpu core that executes one opcode slot, one memory write or one
// host push per input transfer; a none-kind transfer only reports state.
// ----------------------------------------------------------------------------
// Each input transfer has a read phase and an execute phase: the accept edge
// issues the reads of the word memory, the data stack memory and the return
// stack memory (all synchronous and registered), and the next edge executes
// and writes back, loading the result register. No new transfer is taken
// while busy or while a result waits for m_tready, so a transfer never
// overlaps the one before, as the read-then-write use of the single-port word
// memory needs. The top of the data stack lives in a register; the memory
// holds the entries beneath it. MEM_WORDS must be a power of two.
module stack_cpu_core_step #(
	parameter int unsigned MEM_WORDS          = scc_pkg::MemWordsDef,
	parameter int unsigned DATA_STACK_DEPTH   = scc_pkg::DataDepthDef,
	parameter int unsigned RETURN_STACK_DEPTH = scc_pkg::ReturnDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // mem_address[11:0], host_value[43:12], zero pad
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// executed_opcode[4:0], top_value[36:5], stack_depth[42:37],
	// program_counter[54:43], builtin_id[86:55], zero pad
	output logic [87:0] m_tdata,
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int unsigned AW  = $clog2(MEM_WORDS);
	localparam int unsigned DW  = $clog2(DATA_STACK_DEPTH);
	localparam int unsigned CW  = $clog2(DATA_STACK_DEPTH + 1);
	localparam int unsigned RW  = $clog2(RETURN_STACK_DEPTH);
	localparam int unsigned RCW = $clog2(RETURN_STACK_DEPTH + 1);

	logic [31:0]  wmem [MEM_WORDS];
	logic [31:0]  dstk [DATA_STACK_DEPTH];
	logic [AW-1:0] rstk [RETURN_STACK_DEPTH];

	logic [CW-1:0]  dcnt_q;
	logic [RCW-1:0] rcnt_q;
	logic [AW-1:0]  pc_q;
	logic [31:0]    a_q;
	logic [31:0]    slot_q;
	logic [31:0]    tos_q;
	logic           busy_q;

	logic [1:0]     kind_s1;
	logic [11:0]    maddr_s1;
	logic [31:0]    hval_s1;
	logic [31:0]    mrd_s1;
	logic [31:0]    dsec_s1;
	logic [AW-1:0]  rrd_s1;

	logic           s_accept;
	logic [4:0]     op_now;
	logic [AW-1:0]  mrd_addr;
	logic [CW-1:0]  dcnt_m2;
	logic [RCW-1:0] rcnt_m1;

	// next state
	logic [CW-1:0]  dcnt_n;
	logic [RCW-1:0] rcnt_n;
	logic [AW-1:0]  pc_n;
	logic [31:0]    a_n;
	logic [31:0]    slot_n;
	logic [31:0]    tos_n;
	logic [1:0]     status_n;
	logic [4:0]     opout_n;
	logic [31:0]    bid_n;
	logic           mwe;
	logic [AW-1:0]  mwaddr;
	logic [31:0]    mwdata;
	logic           dwe;
	logic [DW-1:0]  dwidx;
	logic           rwe;
	logic [RW-1:0]  rwidx;
	logic [AW-1:0]  rwdata;

	assign s_accept = s_tvalid & s_tready;
	assign s_tready = !busy_q && (!m_tvalid || m_tready);
	assign op_now   = slot_q[4:0];
	assign mrd_addr = (op_now == scc_pkg::OP_LOAD_A || op_now == scc_pkg::OP_LOAD_A_INC)
		? a_q[AW-1:0] : pc_q;
	assign dcnt_m2  = dcnt_q - CW'(2);
	assign rcnt_m1  = rcnt_q - RCW'(1);

	always_ff @(posedge clk) begin
		if (s_accept) begin
			kind_s1  <= s_tuser;
			maddr_s1 <= s_tdata[11:0];
			hval_s1  <= s_tdata[43:12];
			mrd_s1   <= wmem[mrd_addr];
			dsec_s1  <= dstk[dcnt_m2[DW-1:0]];
			rrd_s1   <= rstk[rcnt_m1[RW-1:0]];
		end
		if (mwe) begin
			wmem[mwaddr] <= mwdata;
		end
		if (dwe) begin
			dstk[dwidx] <= tos_q;
		end
		if (rwe) begin
			rstk[rwidx] <= rwdata;
		end
	end

	always_comb begin
		logic [CW:0]    need;
		logic [CW:0]    grow;
		logic [CW-1:0]  dcnt_m1;
		logic [AW-1:0]  pc_inc;
		logic [31:0]    maddr_w;
		logic           push;
		logic           pop;
		logic [31:0]    pval;
		need     = '0;
		grow     = '0;
		dcnt_m1  = dcnt_q - CW'(1);
		pc_inc   = pc_q + AW'(1);
		maddr_w  = 32'(maddr_s1);
		push     = 1'b0;
		pop      = 1'b0;
		pval     = '0;
		dcnt_n   = dcnt_q;
		rcnt_n   = rcnt_q;
		pc_n     = pc_q;
		a_n      = a_q;
		slot_n   = slot_q;
		tos_n    = tos_q;
		status_n = scc_pkg::ST_OK;
		opout_n  = '0;
		bid_n    = '0;
		mwe      = 1'b0;
		mwaddr   = maddr_w[AW-1:0];
		mwdata   = hval_s1;
		dwe      = 1'b0;
		dwidx    = dcnt_m1[DW-1:0];
		rwe      = 1'b0;
		rwidx    = rcnt_q[RW-1:0];
		rwdata   = pc_inc;
		if (busy_q) begin
			unique case (kind_s1)
				scc_pkg::KIND_WRITE: begin
					mwe = 1'b1;
				end
				scc_pkg::KIND_PUSH: begin
					if (dcnt_q < CW'(DATA_STACK_DEPTH)) begin
						push = 1'b1;
						pval = hval_s1;
					end else begin
						status_n = scc_pkg::ST_DATA_ERR;
					end
				end
				scc_pkg::KIND_EXEC: begin
					opout_n = op_now;
					unique case (op_now)
						scc_pkg::OP_JMPZ, scc_pkg::OP_JMPN, scc_pkg::OP_DROP,
						scc_pkg::OP_SHR, scc_pkg::OP_SHL, scc_pkg::OP_NOT,
						scc_pkg::OP_STORE_A, scc_pkg::OP_STORE_A_INC: need = (CW+1)'(1);
						scc_pkg::OP_ADD, scc_pkg::OP_SUB, scc_pkg::OP_MUL,
						scc_pkg::OP_AND, scc_pkg::OP_XOR, scc_pkg::OP_OR: need = (CW+1)'(2);
						scc_pkg::OP_DUP: begin
							need = (CW+1)'(1);
							grow = (CW+1)'(1);
						end
						scc_pkg::OP_OVER: begin
							need = (CW+1)'(2);
							grow = (CW+1)'(1);
						end
						scc_pkg::OP_LIT, scc_pkg::OP_LIT_1, scc_pkg::OP_LOAD_A,
						scc_pkg::OP_LOAD_A_INC: grow = (CW+1)'(1);
						default: need = '0;
					endcase
					if ({1'b0, dcnt_q} < need
						|| {1'b0, dcnt_q} + grow > (CW+1)'(DATA_STACK_DEPTH)) begin
						status_n = scc_pkg::ST_DATA_ERR;
					end else if (op_now == scc_pkg::OP_CALL
						&& rcnt_q >= RCW'(RETURN_STACK_DEPTH)) begin
						status_n = scc_pkg::ST_RET_ERR;
					end else if (op_now == scc_pkg::OP_RET && rcnt_q == '0) begin
						status_n = scc_pkg::ST_RET_ERR;
					end else begin
						slot_n = {5'b0, slot_q[31:5]};
						unique case (op_now)
							scc_pkg::OP_FETCH: begin
								slot_n = mrd_s1;
								pc_n   = pc_inc;
							end
							scc_pkg::OP_JMP: begin
								pc_n   = mrd_s1[AW-1:0];
								slot_n = '0;
							end
							scc_pkg::OP_JMPZ: begin
								pc_n = pc_inc;
								if (tos_q == '0) begin
									pc_n   = mrd_s1[AW-1:0];
									slot_n = '0;
								end
							end
							scc_pkg::OP_JMPN: begin
								pc_n = pc_inc;
								if (tos_q[31]) begin
									pc_n   = mrd_s1[AW-1:0];
									slot_n = '0;
								end
							end
							scc_pkg::OP_CALL: begin
								rwe    = 1'b1;
								rcnt_n = rcnt_q + RCW'(1);
								pc_n   = mrd_s1[AW-1:0];
								slot_n = '0;
							end
							scc_pkg::OP_RET: begin
								rcnt_n = rcnt_m1;
								pc_n   = rrd_s1;
								slot_n = '0;
							end
							scc_pkg::OP_DUP: begin
								push = 1'b1;
								pval = tos_q;
							end
							scc_pkg::OP_DROP: pop = 1'b1;
							scc_pkg::OP_OVER: begin
								push = 1'b1;
								pval = dsec_s1;
							end
							scc_pkg::OP_ADD: begin
								pop   = 1'b1;
								tos_n = dsec_s1 + tos_q;
							end
							scc_pkg::OP_SUB: begin
								pop   = 1'b1;
								tos_n = dsec_s1 - tos_q;
							end
							scc_pkg::OP_MUL: begin
								pop   = 1'b1;
								tos_n = dsec_s1 * tos_q;
							end
							scc_pkg::OP_AND: begin
								pop   = 1'b1;
								tos_n = dsec_s1 & tos_q;
							end
							scc_pkg::OP_XOR: begin
								pop   = 1'b1;
								tos_n = dsec_s1 ^ tos_q;
							end
							scc_pkg::OP_OR: begin
								pop   = 1'b1;
								tos_n = dsec_s1 | tos_q;
							end
							scc_pkg::OP_SHR: tos_n = {tos_q[31], tos_q[31:1]};
							scc_pkg::OP_SHL: tos_n = {tos_q[30:0], 1'b0};
							scc_pkg::OP_NOT: tos_n = ~tos_q;
							scc_pkg::OP_LIT: begin
								push = 1'b1;
								pval = mrd_s1;
								pc_n = pc_inc;
							end
							scc_pkg::OP_LIT_1: begin
								push = 1'b1;
								pval = 32'd1;
							end
							scc_pkg::OP_LOAD_A, scc_pkg::OP_LOAD_A_INC: begin
								push = 1'b1;
								pval = mrd_s1;
								if (op_now == scc_pkg::OP_LOAD_A_INC) a_n = a_q + 32'd1;
							end
							scc_pkg::OP_STORE_A, scc_pkg::OP_STORE_A_INC: begin
								mwe    = 1'b1;
								mwaddr = a_q[AW-1:0];
								mwdata = tos_q;
								pop    = 1'b1;
								tos_n  = dsec_s1;
								if (op_now == scc_pkg::OP_STORE_A_INC) a_n = a_q + 32'd1;
							end
							scc_pkg::OP_BUILTIN: begin
								bid_n    = mrd_s1;
								pc_n     = pc_inc;
								status_n = scc_pkg::ST_TRAP;
							end
							default: slot_n = {5'b0, slot_q[31:5]};
						endcase
					end
				end
				default: status_n = scc_pkg::ST_OK;
			endcase
			// old top spills into the memory below the new top
			if (push) begin
				dwe    = (dcnt_q != '0);
				tos_n  = pval;
				dcnt_n = dcnt_q + CW'(1);
			end
			if (pop) begin
				if (op_now == scc_pkg::OP_DROP) tos_n = dsec_s1;
				dcnt_n = dcnt_m1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			dcnt_q   <= '0;
			rcnt_q   <= '0;
			pc_q     <= '0;
			a_q      <= '0;
			slot_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			busy_q <= s_accept;
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (busy_q) begin
				dcnt_q   <= dcnt_n;
				rcnt_q   <= rcnt_n;
				pc_q     <= pc_n;
				a_q      <= a_n;
				slot_q   <= slot_n;
				m_tvalid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] depth_w;
		logic [31:0] pc_w;
		depth_w = 32'(dcnt_n);
		pc_w    = 32'(pc_n);
		if (busy_q) begin
			tos_q   <= tos_n;
			m_tuser <= status_n;
			m_tdata <= {1'b0, bid_n, pc_w[11:0], depth_w[5:0],
				(dcnt_n != '0) ? tos_n : 32'd0, opout_n};
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> busy_q && !s_tready)
		else $error("accepted item not executed in next cycle");
	a_exec_out: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> m_tvalid)
		else $error("executed item gave no result");
	a_dcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= CW'(DATA_STACK_DEPTH))
		else $error("data stack count out of range");
	a_rcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= RCW'(RETURN_STACK_DEPTH))
		else $error("return stack count out of range");

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives memory writes, host pushes and slot executions into the stack cpu
// core step block and checks every result against a behavioral predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class core_scoreboard;
	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  opcode;
		logic [31:0] top;
		logic [5:0]  depth;
		logic [11:0] pc;
		logic [31:0] bid;
	} step_result_t;

	logic [31:0] mem [4096];
	logic [31:0] dstk [32];
	logic [11:0] rstk [32];
	int unsigned dcnt, rcnt;
	logic [11:0] pc;
	logic [31:0] areg, slots;
	step_result_t pending_results [$];
	int errors;
	int traps, derrs, rerrs, checked;

	function new();
		dcnt = 0; rcnt = 0; pc = 0; areg = 0; slots = 0; errors = 0;
		traps = 0; derrs = 0; rerrs = 0; checked = 0;
		foreach (mem[i]) mem[i] = 0;
	endfunction

	function logic [31:0] stream_word();
		logic [31:0] w;
		w = mem[pc];
		pc = pc + 12'd1;
		return w;
	endfunction

	function void goto_addr(logic [31:0] a);
		pc = a[11:0];
		slots = 0;
	endfunction

	function logic [1:0] run_op(scc_pkg::op_t op, output logic [31:0] bid);
		int unsigned need, grow;
		logic [31:0] a, b;
		need = 0; grow = 0; bid = 0;
		case (op)
			scc_pkg::OP_JMPZ, scc_pkg::OP_JMPN, scc_pkg::OP_DROP, scc_pkg::OP_SHR,
			scc_pkg::OP_SHL, scc_pkg::OP_NOT, scc_pkg::OP_STORE_A,
			scc_pkg::OP_STORE_A_INC: need = 1;
			scc_pkg::OP_ADD, scc_pkg::OP_SUB, scc_pkg::OP_MUL, scc_pkg::OP_AND,
			scc_pkg::OP_XOR, scc_pkg::OP_OR: need = 2;
			scc_pkg::OP_DUP: begin need = 1; grow = 1; end
			scc_pkg::OP_OVER: begin need = 2; grow = 1; end
			scc_pkg::OP_LIT, scc_pkg::OP_LIT_1, scc_pkg::OP_LOAD_A,
			scc_pkg::OP_LOAD_A_INC: grow = 1;
			default: ;
		endcase
		if (dcnt < need || dcnt + grow > 32) return scc_pkg::ST_DATA_ERR;
		if (op == scc_pkg::OP_CALL && rcnt >= 32) return scc_pkg::ST_RET_ERR;
		if (op == scc_pkg::OP_RET && rcnt == 0) return scc_pkg::ST_RET_ERR;
		slots = slots >> 5;
		case (op)
			scc_pkg::OP_FETCH: slots = stream_word();
			scc_pkg::OP_JMP: goto_addr(stream_word());
			scc_pkg::OP_JMPZ: begin
				a = stream_word();
				if (dstk[dcnt-1] == 0) goto_addr(a);
			end
			scc_pkg::OP_JMPN: begin
				a = stream_word();
				if (dstk[dcnt-1][31]) goto_addr(a);
			end
			scc_pkg::OP_CALL: begin
				a = stream_word();
				rstk[rcnt] = pc; rcnt++;
				goto_addr(a);
			end
			scc_pkg::OP_RET: begin rcnt--; goto_addr({20'd0, rstk[rcnt]}); end
			scc_pkg::OP_DUP: begin dstk[dcnt] = dstk[dcnt-1]; dcnt++; end
			scc_pkg::OP_DROP: dcnt--;
			scc_pkg::OP_OVER: begin dstk[dcnt] = dstk[dcnt-2]; dcnt++; end
			scc_pkg::OP_ADD, scc_pkg::OP_SUB, scc_pkg::OP_MUL, scc_pkg::OP_AND,
			scc_pkg::OP_XOR, scc_pkg::OP_OR: begin
				dcnt--; b = dstk[dcnt]; a = dstk[dcnt-1];
				case (op)
					scc_pkg::OP_ADD: a = a + b;
					scc_pkg::OP_SUB: a = a - b;
					scc_pkg::OP_MUL: a = a * b;
					scc_pkg::OP_AND: a = a & b;
					scc_pkg::OP_XOR: a = a ^ b;
					default: a = a | b;
				endcase
				dstk[dcnt-1] = a;
			end
			scc_pkg::OP_SHR: dstk[dcnt-1] = $signed(dstk[dcnt-1]) >>> 1;
			scc_pkg::OP_SHL: dstk[dcnt-1] = dstk[dcnt-1] << 1;
			scc_pkg::OP_NOT: dstk[dcnt-1] = ~dstk[dcnt-1];
			scc_pkg::OP_LIT: begin dstk[dcnt] = stream_word(); dcnt++; end
			scc_pkg::OP_LIT_1: begin dstk[dcnt] = 32'd1; dcnt++; end
			scc_pkg::OP_LOAD_A, scc_pkg::OP_LOAD_A_INC: begin
				dstk[dcnt] = mem[areg[11:0]]; dcnt++;
				if (op == scc_pkg::OP_LOAD_A_INC) areg++;
			end
			scc_pkg::OP_STORE_A, scc_pkg::OP_STORE_A_INC: begin
				dcnt--; mem[areg[11:0]] = dstk[dcnt];
				if (op == scc_pkg::OP_STORE_A_INC) areg++;
			end
			scc_pkg::OP_BUILTIN: begin bid = stream_word(); return scc_pkg::ST_TRAP; end
			default: ;
		endcase
		return scc_pkg::ST_OK;
	endfunction

	function void note_input(logic [1:0] kind, logic [11:0] addr, logic [31:0] val);
		step_result_t r;
		logic [31:0] bid;
		r = '0; bid = 0;
		case (kind)
			scc_pkg::KIND_WRITE: mem[addr] = val;
			scc_pkg::KIND_PUSH:
				if (dcnt < 32) begin dstk[dcnt] = val; dcnt++; end
				else r.status = scc_pkg::ST_DATA_ERR;
			scc_pkg::KIND_EXEC: begin
				r.opcode = slots[4:0];
				r.status = run_op(scc_pkg::op_t'(slots[4:0]), bid);
			end
			default: ;
		endcase
		r.top = dcnt ? dstk[dcnt-1] : 32'd0;
		r.depth = 6'(dcnt);
		r.pc = pc;
		r.bid = (r.status == scc_pkg::ST_TRAP) ? bid : 32'd0;
		if (r.status == scc_pkg::ST_TRAP) traps++;
		if (r.status == scc_pkg::ST_DATA_ERR) derrs++;
		if (r.status == scc_pkg::ST_RET_ERR) rerrs++;
		pending_results.push_back(r);
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h want %h", what, got, want);
	endtask

	task check_result(logic [1:0] st, logic [87:0] d);
		step_result_t w;
		checked++;
		if (pending_results.size() == 0) begin
			report("unexpected transfer", d[31:0], 32'd0);
			return;
		end
		w = pending_results.pop_front();
		if (st !== w.status) report("status", 32'(st), 32'(w.status));
		if (d[4:0] !== w.opcode) report("opcode", 32'(d[4:0]), 32'(w.opcode));
		if (d[36:5] !== w.top) report("top_value", d[36:5], w.top);
		if (d[42:37] !== w.depth) report("stack_depth", 32'(d[42:37]), 32'(w.depth));
		if (d[54:43] !== w.pc) report("program_counter", 32'(d[54:43]), 32'(w.pc));
		if (d[86:55] !== w.bid) report("builtin_id", d[86:55], w.bid);
		if (d[87] !== 1'b0) report("pad", 32'(d[87]), 32'd0);
	endtask
endclass

module testbench;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
	logic [47:0] s_tdata = 0;
	logic [1:0] s_tuser = 0, m_tuser;
	logic [87:0] m_tdata;
	int src_idle = 0, dst_stall = 0;
	longint cycles = 0;
	bit written [4096];
	core_scoreboard sb;

	stack_cpu_core_step u_top (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver side: check on transfer, then choose the next ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
			m_tready <= ($urandom_range(99) >= dst_stall);
		end
	end

	// tvalid stays high after a transfer until the next item or an idle cycle
	task automatic send(logic [1:0] kind, logic [11:0] addr, logic [31:0] val);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= {4'd0, val, addr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(kind, addr, val);
		if (kind == scc_pkg::KIND_WRITE) written[addr] = 1;
	endtask

	task automatic write_word(logic [11:0] a, logic [31:0] v);
		send(scc_pkg::KIND_WRITE, a, v);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		do @(posedge clk); while (sb.pending_results.size() != 0);
	endtask

	function automatic logic [31:0] pack_ops(logic [4:0] o0, logic [4:0] o1, logic [4:0] o2,
			logic [4:0] o3, logic [4:0] o4, logic [4:0] o5);
		return {2'b00, o5, o4, o3, o2, o1, o0};
	endfunction

	// random legal opcode, avoiding loads of unwritten memory
	function automatic logic [4:0] pick_op();
		logic [4:0] o;
		o = 5'($urandom_range(31));
		if (o == scc_pkg::OP_FETCH || o == scc_pkg::OP_LOAD_A || o == scc_pkg::OP_LOAD_A_INC)
			o = scc_pkg::OP_DUP;
		return o;
	endfunction

	// fill memory with a random program whose stream words are all defined
	task automatic load_program();
		logic [31:0] w;
		for (int a = 0; a < 256; a++) begin
			case ($urandom_range(3))
				0: w = pack_ops(pick_op(), pick_op(), pick_op(), pick_op(), pick_op(), pick_op());
				1: w = $urandom_range(255);
				2: w = $urandom();
				default: w = {$urandom_range(1) ? 2'b11 : 2'b00, 30'($urandom())};
			endcase
			// jump targets stay in the written window
			if (w < 4096) w = w % 256;
			write_word(12'(a), w);
		end
	endtask

	// execute only when every stream word the step may read is defined
	function automatic bit exec_safe();
		logic [4:0] o;
		o = sb.slots[4:0];
		if (!written[sb.pc]) return 0;
		if ((o == scc_pkg::OP_LOAD_A || o == scc_pkg::OP_LOAD_A_INC) && !written[sb.areg[11:0]])
			return 0;
		if (o == scc_pkg::OP_JMP || o == scc_pkg::OP_JMPZ || o == scc_pkg::OP_JMPN
			|| o == scc_pkg::OP_CALL)
			return sb.mem[sb.pc] < 4096 ? written[sb.mem[sb.pc][11:0]] : 0;
		if (o == scc_pkg::OP_RET) return sb.rcnt == 0 || written[sb.rstk[sb.rcnt-1]];
		return 1;
	endfunction

	task automatic random_item();
		int r;
		r = $urandom_range(99);
		if (r < 8) write_word(12'($urandom_range(255)), $urandom());
		else if (r < 18 || !exec_safe()) send(scc_pkg::KIND_PUSH, 12'($urandom()), $urandom());
		else if (r < 20) send(scc_pkg::KIND_NONE, 12'($urandom()), $urandom());
		else send(scc_pkg::KIND_EXEC, 12'($urandom()), $urandom());
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, a program that holds every opcode, wrap, traps, stack errors
		write_word(12'd4095, 32'hFFFF_FFFF);
		write_word(12'd0, pack_ops(scc_pkg::OP_LIT, scc_pkg::OP_LIT_1, scc_pkg::OP_ADD,
			scc_pkg::OP_SUB, scc_pkg::OP_MUL, scc_pkg::OP_NOP));
		write_word(12'd1, 32'h8000_0000);
		write_word(12'd2, pack_ops(scc_pkg::OP_DUP, scc_pkg::OP_OVER, scc_pkg::OP_SHR,
			scc_pkg::OP_SHL, scc_pkg::OP_NOT, scc_pkg::OP_AND));
		write_word(12'd3, pack_ops(scc_pkg::OP_XOR, scc_pkg::OP_OR, scc_pkg::OP_DROP,
			scc_pkg::OP_STORE_A, scc_pkg::OP_LOAD_A, 5'd10));
		write_word(12'd4, pack_ops(scc_pkg::OP_STORE_A_INC, scc_pkg::OP_LOAD_A_INC,
			scc_pkg::OP_BUILTIN, 5'd29, 5'd30, 5'd11));
		write_word(12'd5, 32'h7FFF_FFFF);
		send(scc_pkg::KIND_PUSH, 12'd0, 32'h8000_0000);
		send(scc_pkg::KIND_PUSH, 12'd0, 32'h7FFF_FFFF);
		send(scc_pkg::KIND_NONE, 12'hFFF, 32'hFFFF_FFFF);
		repeat (20) send(scc_pkg::KIND_EXEC, 12'hFFF, 32'd0);
		write_word(12'd6, pack_ops(scc_pkg::OP_CALL, scc_pkg::OP_FETCH, 5'd0, 5'd0, 5'd0, 5'd0));
		write_word(12'd7, 32'd4095);
		write_word(12'd4095, pack_ops(scc_pkg::OP_RET, scc_pkg::OP_RET, scc_pkg::OP_JMPZ,
			scc_pkg::OP_JMPN, scc_pkg::OP_JMP, 5'd0));
		for (int a = 0; a < 8; a++) written[a] = 1;
		drain();

		load_program();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle = 0;  dst_stall = 0;  end
				1: begin src_idle = 50; dst_stall = 0;  end
				2: begin src_idle = 0;  dst_stall = 50; end
				default: begin src_idle = 37; dst_stall = 37; end
			endcase
			for (int i = 0; i < 280; i++) begin
				random_item();
				// hold off until the core has caught up
				if (i == 100) drain();
				// overflow stress: pile up pushes
				if (i == 200) repeat (34) send(scc_pkg::KIND_PUSH, 12'd0, $urandom());
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("ran %0d steps: %0d traps, %0d data stack and %0d return stack errors",
			sb.checked, sb.traps, sb.derrs, sb.rerrs);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
